[rtl/websocket_frame_deframer_defines.svh]
// Assertion macros shared by the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Assert a property on an explicit clock and active-low reset.
`define WSFD_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on the block clock and reset.
`define WSFD_ASSERT(label, prop, msg) \
  `WSFD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[rtl/wsfd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

  localparam int unsigned MaxLenW = 24;

  localparam logic [MaxLenW-1:0] MaxLenReset = 24'd524288;
  localparam logic [3:0]         OpClose     = 4'h8;
  localparam logic [6:0]         Len16Code   = 7'd126;
  localparam logic [6:0]         Len64Code   = 7'd127;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    kind_e      kind;
    logic       last;
    logic       stream_end;
  } res_t;

endpackage

[rtl/wsfd_if.sv]
// Valid/ready channel interfaces of the deframer: byte input, result output, config write.
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [3:0] frame_opcode;
  logic [1:0] kind;
  logic       last;
  logic       stream_end;

  modport source (output valid, output data_byte, output frame_opcode, output kind,
                  output last, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input frame_opcode, input kind,
                  input last, input stream_end, output ready);
endinterface

interface wsfd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wsfd_pkg::MaxLenW-1:0] max_payload_bytes;

  modport source (output valid, output max_payload_bytes, input ready);
  modport sink   (input valid, input max_payload_bytes, output ready);
endinterface

[rtl/websocket_frame_deframer.sv]
// A byte taken from in_i reaches out_o through two registers: input, then result register.
// Throughput: one byte per cycle unless out_o stalls; one core state update per byte.
// The input register is free to refill while a finished result waits in the output register.
// Reset (rst_ni low, asynchronous): parser back to first header byte, both stages empty,
// max_payload_bytes back to 524288. A close frame or an oversize error stops it until reset.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsfd_in_if.sink     in_i,
  wsfd_out_if.source  out_o,
  wsfd_cfg_if.sink    cfg_i
);

  // Configuration register: always ready, written whenever valid.
  logic [wsfd_pkg::MaxLenW-1:0] max_len_q;

  // Input register stage.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Result register stage.
  logic           out_valid_q, out_valid_d;
  wsfd_pkg::res_t out_q;

  // Core outputs.
  logic           res_valid;
  wsfd_pkg::res_t res;

  logic advance;
  logic in_take;

  assign cfg_i.ready = 1'b1;

  // Advance the held byte once the result slot is free or being emptied this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= wsfd_pkg::MaxLenReset;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_payload_bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_take || (in_valid_q && !advance);
    end
  end

  // Hold the payload unless a new transaction lands.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  wsfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // A byte without result still empties the slot, as any old result was taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.data_byte    = out_q.data_byte;
  assign out_o.frame_opcode = out_q.frame_opcode;
  assign out_o.kind         = out_q.kind;
  assign out_o.last         = out_q.last;
  assign out_o.stream_end   = out_q.stream_end;

endmodule

[rtl/wsfd_core.sv]
// Frame parser state: header decode, length, mask key and payload unmasking.
module wsfd_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [7:0]                   byte_i,
  input  logic [wsfd_pkg::MaxLenW-1:0] max_len_i,
  output logic                         res_valid_o,
  output wsfd_pkg::res_t               res_o
);

  localparam logic [2:0] PhHdr0    = 3'd0;
  localparam logic [2:0] PhHdr1    = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhKey     = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [3:0]  ext_q, ext_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  pos_q, pos_d;
  logic        stopped_q, stopped_d;

  logic        len_done;
  logic        hdr_done;
  logic [6:0]  len7;
  logic [7:0]  key_byte;

  assign len7 = byte_i[6:0];

  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    mask_d      = mask_q;
    ext_d       = ext_q;
    rem_d       = rem_q;
    key_d       = key_q;
    pos_d       = pos_q;
    stopped_d   = stopped_q;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.frame_opcode = opcode_q;

    if (step_i && !stopped_q) begin
      case (phase_q)
        PhHdr1: begin
          mask_d = byte_i[7];
          rem_d  = '0;
          if (len7 == wsfd_pkg::Len16Code) begin
            ext_d   = 4'd2;
            phase_d = PhExtLen;
          end else if (len7 == wsfd_pkg::Len64Code) begin
            ext_d   = 4'd8;
            phase_d = PhExtLen;
          end else begin
            rem_d    = {57'd0, len7};
            len_done = 1'b1;
          end
        end
        PhExtLen: begin
          rem_d = {rem_q[55:0], byte_i};
          ext_d = ext_q - 4'd1;
          if (ext_d == 4'd0) begin
            len_done = 1'b1;
          end
        end
        PhKey: begin
          key_d = {key_q[23:0], byte_i};
          if (pos_q == 2'd3) begin
            hdr_done = 1'b1;
          end else begin
            pos_d = pos_q + 2'd1;
          end
        end
        PhPayload: begin
          pos_d       = pos_q + 2'd1;
          rem_d       = rem_q - 64'd1;
          res_valid_o = 1'b1;
          res_o.data_byte = byte_i ^ key_byte;
          res_o.kind      = wsfd_pkg::KIND_PAYLOAD;
          // Final byte of the frame when one byte was left before this one.
          if (rem_q == 64'd1) begin
            res_o.last = 1'b1;
            phase_d    = PhHdr0;
            if (opcode_q == wsfd_pkg::OpClose) begin
              res_o.stream_end = 1'b1;
              stopped_d        = 1'b1;
            end
          end
        end
        default: begin
          opcode_d = byte_i[3:0];
          phase_d  = PhHdr1;
        end
      endcase

      // Length known: collect the key first if the frame is masked.
      if (len_done) begin
        key_d = '0;
        if (mask_d) begin
          pos_d   = 2'd0;
          phase_d = PhKey;
        end else begin
          hdr_done = 1'b1;
        end
      end

      // Header complete: size check, empty frame or payload.
      if (hdr_done) begin
        pos_d = 2'd0;
        if (rem_d > {40'd0, max_len_i}) begin
          stopped_d        = 1'b1;
          phase_d          = PhHdr0;
          res_valid_o      = 1'b1;
          res_o.kind       = wsfd_pkg::KIND_ERROR;
          res_o.last       = 1'b1;
          res_o.stream_end = 1'b1;
        end else if (rem_d == 64'd0) begin
          stopped_d        = (opcode_q == wsfd_pkg::OpClose);
          phase_d          = PhHdr0;
          res_valid_o      = 1'b1;
          res_o.kind       = wsfd_pkg::KIND_EMPTY;
          res_o.last       = 1'b1;
          res_o.stream_end = (opcode_q == wsfd_pkg::OpClose);
        end else begin
          phase_d = PhPayload;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHdr0;
      opcode_q  <= '0;
      mask_q    <= 1'b0;
      ext_q     <= '0;
      rem_q     <= '0;
      key_q     <= '0;
      pos_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      mask_q    <= mask_d;
      ext_q     <= ext_d;
      rem_q     <= rem_d;
      key_q     <= key_d;
      pos_q     <= pos_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

[rtl/wsfd_checker.sv]
// Port-level checker for the deframer, bound to the top level.
`include "websocket_frame_deframer_defines.svh"

module wsfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] data_byte_i,
  input logic [1:0] kind_i,
  input logic       last_i,
  input logic       stream_end_i
);

  `WSFD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `WSFD_ASSERT(a_end_last, out_valid_i && stream_end_i |-> last_i, "stream end without last")
  `WSFD_ASSERT(a_err_end, out_valid_i && kind_i == wsfd_pkg::KIND_ERROR |-> stream_end_i, "error without stream end")
  `WSFD_ASSERT(a_data_zero, out_valid_i && kind_i != wsfd_pkg::KIND_PAYLOAD |-> data_byte_i == 8'd0, "data on non-payload")
  `WSFD_ASSERT(a_stop_quiet, out_valid_i && out_ready_i && stream_end_i |=> !out_valid_i, "result after stream end")

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .data_byte_i  (out_o.data_byte),
  .kind_i       (out_o.kind),
  .last_i       (out_o.last),
  .stream_end_i (out_o.stream_end)
);
